// ----- src/ipid_pkg.sv -----
package ipid_pkg;

  // Field and register widths
  localparam int DATA_W     = 16;
  localparam int ERR_W      = DATA_W + 1;      // target - measured
  localparam int DP_W       = ERR_W + 1;       // e - e1
  localparam int DD_W       = ERR_W + 2;       // e - 2*e1 + e2
  localparam int PROD_W     = DATA_W + DD_W;   // widest gain product
  localparam int SUM_W      = PROD_W + 2;      // sum of three products
  localparam int CFG_ADDR_W = 3;
  localparam int IN_DATA_W  = 2 * DATA_W;

  localparam int DEF_GAIN_FRAC_BITS = 12;

  // Register reset values
  localparam logic signed [DATA_W-1:0] FLOOR_RST = 16'sh8000;
  localparam logic signed [DATA_W-1:0] CEIL_RST  = 16'sh7FFF;

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_GAIN_P = 3'd0,
    CFG_GAIN_I = 3'd1,
    CFG_GAIN_D = 3'd2,
    CFG_FLOOR  = 3'd3,
    CFG_CEIL   = 3'd4
  } cfg_idx_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
    logic signed [DATA_W-1:0] floor_lim;
    logic signed [DATA_W-1:0] ceil_lim;
  } cfg_t;

  // Product stage contents
  typedef struct packed {
    logic                     clear;
    logic signed [PROD_W-1:0] prod_p;
    logic signed [PROD_W-1:0] prod_i;
    logic signed [PROD_W-1:0] prod_d;
  } prod_t;

endpackage

// ----- src/ipid_cfg_regs.sv -----
module ipid_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ipid_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ipid_pkg::DATA_W-1:0]     cfg_wdata,
  output ipid_pkg::cfg_t                  cfg
);
  import ipid_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write into the selected register
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_GAIN_P: cfg_nxt.gain_p    = cfg_wdata;
        CFG_GAIN_I: cfg_nxt.gain_i    = cfg_wdata;
        CFG_GAIN_D: cfg_nxt.gain_d    = cfg_wdata;
        CFG_FLOOR:  cfg_nxt.floor_lim = cfg_wdata;
        CFG_CEIL:   cfg_nxt.ceil_lim  = cfg_wdata;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p    <= '0;
      cfg_r.gain_i    <= '0;
      cfg_r.gain_d    <= '0;
      cfg_r.floor_lim <= FLOOR_RST;
      cfg_r.ceil_lim  <= CEIL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/ipid_front.sv -----
module ipid_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ipid_pkg::cfg_t                 cfg,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic                           in_tuser,   // [0] action
  input  logic [ipid_pkg::IN_DATA_W-1:0] in_tdata,   // [15:0] target, [31:16] measured
  output ipid_pkg::prod_t                prod,
  output logic                           prod_valid,
  input  logic                           prod_ready
);
  import ipid_pkg::*;

  // Input register
  logic                     a_valid_r;
  logic                     a_clear_r;
  logic signed [DATA_W-1:0] a_target_r;
  logic signed [DATA_W-1:0] a_meas_r;

  // Product register
  logic  b_valid_r;
  prod_t b_r;
  prod_t b_nxt;

  // Error history
  logic signed [ERR_W-1:0] e1_r;
  logic signed [ERR_W-1:0] e2_r;
  logic signed [ERR_W-1:0] e1_nxt;
  logic signed [ERR_W-1:0] e2_nxt;

  logic signed [ERR_W-1:0] err;
  logic signed [DP_W-1:0]  dp;
  logic signed [DD_W-1:0]  dd;

  logic b_ready;
  logic a_ready;
  logic ld_b;

  assign b_ready   = !b_valid_r || prod_ready;
  assign ld_b      = a_valid_r && b_ready;
  assign a_ready   = !a_valid_r || b_ready;
  assign in_tready = a_ready;

  // Error and its differences
  assign err = ERR_W'(a_target_r) - ERR_W'(a_meas_r);
  assign dp  = DP_W'(err) - DP_W'(e1_r);
  assign dd  = DD_W'(err) - (DD_W'(e1_r) <<< 1) + DD_W'(e2_r);

  // Gain products and history update
  always_comb begin
    b_nxt.clear  = a_clear_r;
    b_nxt.prod_p = PROD_W'(cfg.gain_p) * PROD_W'(dp);
    b_nxt.prod_i = PROD_W'(cfg.gain_i) * PROD_W'(err);
    b_nxt.prod_d = PROD_W'(cfg.gain_d) * PROD_W'(dd);
    if (a_clear_r) begin
      e1_nxt = '0;
      e2_nxt = '0;
    end else begin
      e1_nxt = err;
      e2_nxt = e1_r;
    end
  end

  // Advance the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      e1_r      <= '0;
      e2_r      <= '0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_tvalid;
      end
      if (ld_b) begin
        b_valid_r <= 1'b1;
        e1_r      <= e1_nxt;
        e2_r      <= e2_nxt;
      end else if (prod_ready) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && a_ready) begin
      a_clear_r  <= in_tuser;
      a_target_r <= in_tdata[DATA_W-1:0];
      a_meas_r   <= in_tdata[IN_DATA_W-1:DATA_W];
    end
    if (ld_b) begin
      b_r <= b_nxt;
    end
  end

  assign prod       = b_r;
  assign prod_valid = b_valid_r;

`ifndef NO_ASSERTIONS
  a_clear_hist: assert property (@(posedge clk) disable iff (!rst_n)
    ld_b && a_clear_r |=> e1_r == '0 && e2_r == '0)
    else $error("error history not cleared");

  a_shift_hist: assert property (@(posedge clk) disable iff (!rst_n)
    ld_b && !a_clear_r |=> e2_r == $past(e1_r))
    else $error("error history did not shift");

  a_hold_hist: assert property (@(posedge clk) disable iff (!rst_n)
    !ld_b |=> $stable(e1_r) && $stable(e2_r))
    else $error("error history changed without an item");
`endif

endmodule

// ----- src/ipid_out.sv -----
module ipid_out #(
  parameter int GAIN_FRAC_BITS = ipid_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ipid_pkg::cfg_t              cfg,
  input  ipid_pkg::prod_t             prod,
  input  logic                        prod_valid,
  output logic                        prod_ready,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ipid_pkg::DATA_W-1:0] out_tdata   // [15:0] drive
);
  import ipid_pkg::*;

  localparam int DU_W  = SUM_W - GAIN_FRAC_BITS;
  localparam int EXT_W = DU_W + 1;

  logic signed [DATA_W-1:0] accum_r;
  logic signed [DATA_W-1:0] accum_nxt;
  logic signed [DATA_W-1:0] drive_r;
  logic                     out_valid_r;

  logic signed [SUM_W-1:0] sum;
  logic signed [DU_W-1:0]  du;
  logic signed [EXT_W-1:0] acc_x;
  logic signed [EXT_W-1:0] du_x;
  logic signed [EXT_W-1:0] ceil_x;
  logic signed [EXT_W-1:0] floor_x;
  logic signed [EXT_W-1:0] tmp;
  logic signed [EXT_W-1:0] room;
  logic signed [EXT_W-1:0] du_adj;
  logic signed [EXT_W-1:0] o_raw;
  logic signed [EXT_W-1:0] o_clamp;
  logic                    ld_c;

  assign prod_ready = !out_valid_r || out_tready;
  assign ld_c       = prod_valid && prod_ready;

  // Sum the products and drop the gain fraction
  assign sum = SUM_W'(prod.prod_p) + SUM_W'(prod.prod_i) + SUM_W'(prod.prod_d);
  assign du  = DU_W'(sum >>> GAIN_FRAC_BITS);

  assign acc_x   = EXT_W'(accum_r);
  assign du_x    = EXT_W'(du);
  assign ceil_x  = EXT_W'(cfg.ceil_lim);
  assign floor_x = EXT_W'(cfg.floor_lim);
  assign tmp     = acc_x + du_x;

  // Anti-windup: trim an increment that pushes past a limit
  always_comb begin
    du_adj = du_x;
    room   = '0;
    if (tmp > ceil_x) begin
      if (du_x > 0) begin
        room   = ceil_x - acc_x;
        du_adj = (room < 0) ? '0 : room;
      end
    end else if (tmp < floor_x) begin
      if (du_x < 0) begin
        room   = floor_x - acc_x;
        du_adj = (room > 0) ? '0 : room;
      end
    end
  end

  // Accumulate and clamp
  assign o_raw = acc_x + du_adj;

  always_comb begin
    if (o_raw > ceil_x) begin
      o_clamp = ceil_x;
    end else if (o_raw < floor_x) begin
      o_clamp = floor_x;
    end else begin
      o_clamp = o_raw;
    end
    if (prod.clear) begin
      accum_nxt = '0;
    end else begin
      accum_nxt = o_clamp[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      accum_r     <= '0;
    end else begin
      if (ld_c) begin
        out_valid_r <= 1'b1;
        accum_r     <= accum_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ld_c) begin
      drive_r <= accum_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = drive_r;

`ifndef NO_ASSERTIONS
  a_clear_out: assert property (@(posedge clk) disable iff (!rst_n)
    ld_c && prod.clear |=> accum_r == '0)
    else $error("output not cleared by clear item");

  a_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    ld_c && !prod.clear && cfg.floor_lim <= cfg.ceil_lim
      |=> accum_r >= cfg.floor_lim && accum_r <= cfg.ceil_lim)
    else $error("output outside limits");

  a_drive_accum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> drive_r == accum_r)
    else $error("result differs from accumulator");
`endif

endmodule

// ----- src/incremental_pid_with_antiwindup_top.sv -----
// Incremental PID controller with anti-windup, Q1.15 data and Q4.12 gains.
// Input channel in_*: in_tuser is the action (0 = update, 1 = clear history
// and output); in_tdata carries target in [15:0] and measured in [31:16].
// Result channel out_*: one item per input item, drive in out_tdata[15:0].
// Configuration: cfg_we with cfg_addr 0..4 writes proportional, integral and
// derivative gain, output floor and output ceiling; other addresses do nothing.
// Write the registers only while no item is in flight.
// Path: the input register takes an accepted item, the product register
// follows, and the result leaves from the output register.
// Throughput: one item per cycle while out_tready is high; the three gain products
// are formed in parallel and the accumulate/clamp loop closes through one register.
// Reset (rst_n low, synchronous) clears error history, output accumulator and
// gains, and sets the limits to -1.0 and just below +1.0.
// When out_tready is low the result holds; the two inner stages still fill,
// so up to two more items are taken before in_tready drops.
module incremental_pid_with_antiwindup_top #(
  parameter int GAIN_FRAC_BITS = ipid_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic                            in_tuser,   // [0] action
  input  logic [ipid_pkg::IN_DATA_W-1:0]  in_tdata,   // [15:0] target, [31:16] measured
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ipid_pkg::DATA_W-1:0]     out_tdata,  // [15:0] drive
  input  logic                            cfg_we,
  input  logic [ipid_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ipid_pkg::DATA_W-1:0]     cfg_wdata
);
  import ipid_pkg::*;

  cfg_t  cfg;
  prod_t prod;
  logic  prod_valid;
  logic  prod_ready;

  ipid_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ipid_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .prod       (prod),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready)
  );

  ipid_out #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .prod       (prod),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
